FILE: hdl/tce_pkg.sv
// ============================================================================
// tce_pkg - shared types and constants of the text cursor engine
// Item and result words, internal command word, register indexes, op codes.
// ============================================================================
package tce_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int CELL_SIZE   = 8;
    localparam int COORD_MAX   = (1 << COORD_WIDTH) - 1;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 13;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLIP_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLIP_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAB_CELLS   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRAP_ENABLE = 3'd5;

    localparam logic [11:0] RST_CLIP_LEFT   = 12'd0;
    localparam logic [11:0] RST_CLIP_TOP    = 12'd0;
    localparam logic [12:0] RST_CLIP_WIDTH  = 13'd640;
    localparam logic [12:0] RST_CLIP_HEIGHT = 13'd480;
    localparam logic [4:0]  RST_TAB_CELLS   = 5'd4;
    localparam logic        RST_WRAP_ENABLE = 1'b1;

    // input function codes
    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    // character codes
    localparam logic [20:0] CH_TAB     = 21'd9;
    localparam logic [20:0] CH_NEWLINE = 21'd10;
    localparam logic [20:0] CH_RETURN  = 21'd13;
    localparam logic [20:0] CH_FIRST   = 21'd32;
    localparam logic [20:0] CH_LAST    = 21'd127;
    localparam logic [6:0]  GLYPH_SUBST = 7'd63;

    // result kinds
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // internal op codes
    localparam int OP_WIDTH = 3;
    localparam logic [OP_WIDTH-1:0] OP_SET     = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_NEWLINE = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_RETURN  = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_TAB     = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_PUT     = 3'd4;

    localparam int CQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    typedef struct packed {
        logic        func;
        logic [20:0] code_point;
        logic [11:0] new_x;
        logic [11:0] new_y;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [6:0]  glyph;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [OP_WIDTH-1:0] op;
        logic [6:0]          glyph;
        logic [11:0]         new_x;
        logic [11:0]         new_y;
    } cmd_t;

endpackage

FILE: hdl/tce_front.sv
// ============================================================================
// tce_front - input classifier and command queue
// Decodes each input word into an op code and glyph, holds it for the back end.
// ============================================================================
module tce_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tce_pkg::in_item_t item,
    output logic             cmd_valid,
    output tce_pkg::cmd_t    cmd,
    input  logic             cmd_pop
);

    localparam int PTR_W = (tce_pkg::CQ_DEPTH > 1) ? $clog2(tce_pkg::CQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(tce_pkg::CQ_DEPTH + 1);

    tce_pkg::cmd_t    cq_reg [tce_pkg::CQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    tce_pkg::cmd_t    dec;
    logic             wr_en;

    always_comb
    begin
        dec.new_x = item.new_x;
        dec.new_y = item.new_y;
        if ((item.code_point < tce_pkg::CH_FIRST) || (item.code_point > tce_pkg::CH_LAST))
        begin
            dec.glyph = tce_pkg::GLYPH_SUBST;
        end
        else
        begin
            dec.glyph = item.code_point[6:0];
        end
        if (item.func == tce_pkg::FUNC_SET)
        begin
            dec.op = tce_pkg::OP_SET;
        end
        else
        begin
            unique case (item.code_point)
                tce_pkg::CH_NEWLINE: dec.op = tce_pkg::OP_NEWLINE;
                tce_pkg::CH_RETURN:  dec.op = tce_pkg::OP_RETURN;
                tce_pkg::CH_TAB:     dec.op = tce_pkg::OP_TAB;
                default:             dec.op = tce_pkg::OP_PUT;
            endcase
        end
    end

    assign full      = (count_reg == CNT_W'(tce_pkg::CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cq_reg[rd_ptr_reg];
    assign wr_en     = push && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tce_pkg::CQ_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tce_pkg::CQ_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cq_reg[wr_ptr_reg] <= dec;
        end
    end

    // back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> count_reg != '0)
        else $error("command queue underflow");

endmodule

FILE: hdl/tce_out_queue.sv
// ============================================================================
// tce_out_queue - result queue
// Holds result words until the consumer pops them; reports room for two more.
// ============================================================================
module tce_out_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  tce_pkg::out_item_t wr_word,
    output logic               room2,
    output logic               empty,
    input  logic               pop,
    output tce_pkg::out_item_t result
);

    localparam int PTR_W = $clog2(tce_pkg::OQ_DEPTH);
    localparam int CNT_W = $clog2(tce_pkg::OQ_DEPTH + 1);

    tce_pkg::out_item_t oq_reg [tce_pkg::OQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rd_en;

    assign empty  = (count_reg == '0);
    assign room2  = (count_reg <= CNT_W'(tce_pkg::OQ_DEPTH - 2));
    assign result = oq_reg[rd_ptr_reg];
    assign rd_en  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            oq_reg[wr_ptr_reg] <= wr_word;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> count_reg != CNT_W'(tce_pkg::OQ_DEPTH))
        else $error("result queue overflow");

endmodule

FILE: hdl/tce_back.sv
// ============================================================================
// tce_back - cursor sequencer
// Holds the window registers and the cursor, executes one command at a time
// and writes scroll and draw words into the result queue.
// ============================================================================
module tce_back
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [tce_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [tce_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    input  logic                                    cmd_valid,
    input  tce_pkg::cmd_t                           cmd,
    output logic                                    cmd_pop,
    input  logic                                    room2,
    output logic                                    oq_push,
    output tce_pkg::out_item_t                      oq_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_TAB  = 3'd3;
    localparam logic [2:0] ST_DRAW = 3'd4;

    localparam int BITS_PER_STEP = 3;
    localparam int DIV_STEPS     = 3;   // 9-bit cell index, 3 bits a cycle

    localparam logic [11:0] CMAX = 12'(tce_pkg::COORD_MAX);

    // one restoring remainder step; r < t on entry and exit
    function automatic logic [4:0] rem_step(input logic [4:0] r, input logic b,
                                            input logic [4:0] t);
        logic [5:0] x;
        x = {r, b};
        if (x >= {1'b0, t})
        begin
            return 5'(x - {1'b0, t});
        end
        return x[4:0];
    endfunction

    logic [2:0]  state_reg, state_next;
    tce_pkg::cmd_t cmd_reg, cmd_next;
    logic [11:0] cx_reg, cx_next;
    logic [11:0] cy_reg, cy_next;

    logic [11:0] clip_left_reg;
    logic [11:0] clip_top_reg;
    logic [12:0] clip_width_reg;
    logic [12:0] clip_height_reg;
    logic [4:0]  tab_cells_reg;
    logic        wrap_reg;

    logic [8:0]  q_reg, q_next;
    logic [4:0]  rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [1:0]  div_cnt_reg, div_cnt_next;

    logic [4:0]  tab_eff;
    logic [12:0] y_plus;
    logic        y_over;
    logic [11:0] y1;
    logic [13:0] y1_p8;
    logic [13:0] bottom;
    logic [13:0] bottom_m;
    logic [11:0] bottom_y;
    logic        scroll_c;
    logic [12:0] x_plus;
    logic [11:0] x_adv;
    logic        x_over;
    logic [12:0] dx;
    logic [12:0] dx_mag;
    logic [4:0]  rem_calc;
    logic [5:0]  cells;
    logic [12:0] tab_x;

    // --- window registers -------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= tce_pkg::RST_CLIP_LEFT;
            clip_top_reg    <= tce_pkg::RST_CLIP_TOP;
            clip_width_reg  <= tce_pkg::RST_CLIP_WIDTH;
            clip_height_reg <= tce_pkg::RST_CLIP_HEIGHT;
            tab_cells_reg   <= tce_pkg::RST_TAB_CELLS;
            wrap_reg        <= tce_pkg::RST_WRAP_ENABLE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tce_pkg::REG_CLIP_LEFT:   clip_left_reg   <= cfg_data[11:0];
                tce_pkg::REG_CLIP_TOP:    clip_top_reg    <= cfg_data[11:0];
                tce_pkg::REG_CLIP_WIDTH:  clip_width_reg  <= cfg_data[12:0];
                tce_pkg::REG_CLIP_HEIGHT: clip_height_reg <= cfg_data[12:0];
                tce_pkg::REG_TAB_CELLS:   tab_cells_reg   <= cfg_data[4:0];
                tce_pkg::REG_WRAP_ENABLE: wrap_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // --- datapath ------------------------------------------------------------
    always_comb
    begin
        tab_eff = (tab_cells_reg == '0) ? 5'd1 : tab_cells_reg;

        // newline row, saturated, and the scroll test on it
        y_plus = {1'b0, cy_reg} + 13'(tce_pkg::CELL_SIZE);
        y_over = (y_plus > {1'b0, CMAX});
        y1     = y_over ? CMAX : y_plus[11:0];
        y1_p8  = y_over ? 14'(tce_pkg::COORD_MAX + tce_pkg::CELL_SIZE)
                        : {2'b00, cy_reg} + 14'(2 * tce_pkg::CELL_SIZE);
        bottom = {2'b00, clip_top_reg} + {1'b0, clip_height_reg};
        scroll_c = wrap_reg && (y1_p8 > bottom);
        bottom_m = bottom - 14'(tce_pkg::CELL_SIZE);
        if (bottom < 14'(tce_pkg::CELL_SIZE))
        begin
            bottom_y = '0;
        end
        else if (bottom_m > {2'b00, CMAX})
        begin
            bottom_y = CMAX;
        end
        else
        begin
            bottom_y = bottom_m[11:0];
        end

        // advance by one cell and right edge test
        x_plus = {1'b0, cx_reg} + 13'(tce_pkg::CELL_SIZE);
        x_adv  = (x_plus > {1'b0, CMAX}) ? CMAX : x_plus[11:0];
        x_over = ({1'b0, x_plus} > ({2'b00, clip_left_reg} + {1'b0, clip_width_reg}));

        // signed offset from the left edge, magnitude for the cell index
        dx     = {1'b0, cx_reg} - {1'b0, clip_left_reg};
        dx_mag = dx[12] ? (13'd0 - dx) : dx;

        rem_calc = rem_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            rem_calc = rem_step(rem_calc, q_reg[8 - i], tab_eff);
        end

        // truncating remainder takes the sign of the offset
        cells = neg_reg ? ({1'b0, tab_eff} + {1'b0, rem_reg})
                        : ({1'b0, tab_eff} - {1'b0, rem_reg});
        tab_x = {1'b0, cx_reg} + {4'b0000, cells, 3'b000};
    end

    // --- sequencer -------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        div_cnt_next = div_cnt_reg;
        cmd_pop      = 1'b0;
        oq_push      = 1'b0;
        oq_word.kind  = tce_pkg::KIND_SCROLL;
        oq_word.glyph = '0;
        oq_word.pos_x = '0;
        oq_word.pos_y = '0;
        oq_word.last  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && room2)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (cmd_reg.op)
                    tce_pkg::OP_SET:
                    begin
                        cx_next = cmd_reg.new_x;
                        cy_next = cmd_reg.new_y;
                    end
                    tce_pkg::OP_RETURN:
                    begin
                        cx_next = clip_left_reg;
                    end
                    tce_pkg::OP_NEWLINE:
                    begin
                        cx_next = clip_left_reg;
                        cy_next = scroll_c ? bottom_y : y1;
                        oq_push = scroll_c;
                    end
                    tce_pkg::OP_TAB:
                    begin
                        q_next       = dx_mag[11:3];
                        neg_next     = dx[12];
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                    default:
                    begin
                        // put: wrap first if the cell crosses the right edge; with wrap off, drop it
                        if (!x_over)
                        begin
                            state_next = ST_DRAW;
                        end
                        else if (wrap_reg)
                        begin
                            cx_next      = clip_left_reg;
                            cy_next      = scroll_c ? bottom_y : y1;
                            oq_push      = scroll_c;
                            oq_word.last = 1'b0;
                            state_next   = ST_DRAW;
                        end
                    end
                endcase
            end
            ST_DIV:
            begin
                rem_next     = rem_calc;
                q_next       = q_reg << BITS_PER_STEP;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 2'(DIV_STEPS - 1))
                begin
                    state_next = ST_TAB;
                end
            end
            ST_TAB:
            begin
                cx_next    = (tab_x > {1'b0, CMAX}) ? CMAX : tab_x[11:0];
                state_next = ST_IDLE;
            end
            ST_DRAW:
            begin
                oq_push       = 1'b1;
                oq_word.kind  = tce_pkg::KIND_DRAW;
                oq_word.glyph = cmd_reg.glyph;
                oq_word.pos_x = cx_reg;
                oq_word.pos_y = cy_reg;
                cx_next       = x_adv;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cx_reg      <= '0;
            cy_reg      <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // a word that is not last is a scroll, followed at once by its draw
    a_scroll_then_draw: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push && !oq_word.last |=> oq_push && oq_word.last
                                     && oq_word.kind == tce_pkg::KIND_DRAW)
        else $error("wrap scroll not followed by draw");

    a_draw_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAW |-> $past(state_reg) == ST_EXEC
                                 && cmd_reg.op == tce_pkg::OP_PUT)
        else $error("draw state entered without a put");

    a_tab_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TAB |-> $past(state_reg) == ST_DIV
                                && $past(div_cnt_reg) == 2'(DIV_STEPS - 1))
        else $error("tab finished before remainder");

endmodule

FILE: hdl/text_cursor_engine.sv
// ============================================================================
// text_cursor_engine - text console cursor control
// Cursor tracking, wrap, scroll and tab handling for a clipped text window.
// ============================================================================
// Pushed items enter a two-word command queue; the sequencer runs set,
// return and newline through its execute state, a printed character (with
// or without a wrap scroll) through execute and draw, and a tab through
// execute, divide and tab, forming the cell remainder 3 bits a cycle.
// Results go out in order through a four-word result queue; a command is
// started only when that queue has room for two words, so a stalled consumer
// holds the sequencer while the input side keeps filling the command queue.
module text_cursor_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  tce_pkg::in_item_t                   item,
    output logic                                empty,
    input  logic                                pop,
    output tce_pkg::out_item_t                  result,
    input  logic                                cfg_write,
    input  logic [tce_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tce_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic               cmd_valid;
    tce_pkg::cmd_t      cmd;
    logic               cmd_pop;
    logic               room2;
    logic               oq_push;
    tce_pkg::out_item_t oq_word;

    tce_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tce_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .room2     (room2),
        .oq_push   (oq_push),
        .oq_word   (oq_word)
    );

    tce_out_queue u_out_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_push),
        .wr_word (oq_word),
        .room2   (room2),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
